/* rtl/core/rqb_pkg.sv */
// Shared types and constants of the RSS queue balancer.
// Used by the controller, the datapath and the top level; depends on nothing.
`default_nettype none

package rqb_pkg;

    localparam int WORKER_SLOTS_DEF = 16;
    localparam int QUEUE_COUNT_DEF  = 64;

    localparam int OP_W     = 2;
    localparam int PID_W    = 22;
    localparam int STAMP_W  = 32;
    localparam int TSLOT_W  = 4;
    localparam int NSIZE_W  = 7;
    localparam int STATUS_W = 2;
    localparam int OSLOT_W  = 4;
    localparam int MQ_W     = 6;
    localparam int MCNT_W   = 7;

    localparam logic [PID_W-1:0] CTL_PID_RESET = PID_W'(1);

    localparam logic [OP_W-1:0] OP_BALANCE = 2'd0;
    localparam logic [OP_W-1:0] OP_ADD     = 2'd1;
    localparam logic [OP_W-1:0] OP_DELETE  = 2'd2;
    localparam logic [OP_W-1:0] OP_RESIZE  = 2'd3;

    localparam logic [STATUS_W-1:0] ST_OK      = 2'd0;
    localparam logic [STATUS_W-1:0] ST_DUP_PID = 2'd1;
    localparam logic [STATUS_W-1:0] ST_NO_SLOT = 2'd2;
    localparam logic [STATUS_W-1:0] ST_BAD_ARG = 2'd3;

    // Commands from the controller to the datapath.
    typedef struct packed {
        logic load;
        logic bad;
        logic slot_step;
        logic add_fin;
        logic pick_fin;
        logic q_rd;
        logic q_ev;
        logic grow_wr;
        logic commit;
        logic done;
    } t_cmd;

    // Status from the datapath to the controller.
    typedef struct packed {
        logic [OP_W-1:0] op;
        logic            arg_bad;
        logic            shrink;
        logic            grow;
        logic            has_q;
        logic            slot_last;
        logic            q_end;
        logic            can_move;
        logic            hit;
    } t_sts;

endpackage

`default_nettype wire

/* rtl/core/rqb_ram.sv */
// Generic single write port RAM with one registered read port.
// No dependencies.
`default_nettype none

module rqb_ram #(
    parameter int WIDTH = 8,
    parameter int DEPTH = 64
) (
    input  wire logic                                  i_clk,
    input  wire logic                                  i_we,
    input  wire logic [(DEPTH > 1 ? $clog2(DEPTH) : 1)-1:0] i_waddr,
    input  wire logic [WIDTH-1:0]                      i_wdata,
    input  wire logic                                  i_re,
    input  wire logic [(DEPTH > 1 ? $clog2(DEPTH) : 1)-1:0] i_raddr,
    output logic      [WIDTH-1:0]                      o_rdata
);

    logic [WIDTH-1:0] r_mem [DEPTH];

    always_ff @(posedge i_clk) begin
        if (i_we) begin
            r_mem[i_waddr] <= i_wdata;
        end
        if (i_re) begin
            o_rdata <= r_mem[i_raddr];
        end
    end

endmodule

`default_nettype wire

/* rtl/core/rqb_ctrl.sv */
// Controller state machine of the RSS queue balancer.
// Depends on rqb_pkg for the command and status structs.
`default_nettype none

module rqb_ctrl (
    input  wire logic          i_clk,
    input  wire logic          i_rst_n,
    input  wire logic          i_start,
    input  rqb_pkg::t_sts      i_sts,
    output rqb_pkg::t_cmd      o_cmd,
    output logic               o_busy
);
    import rqb_pkg::*;

    localparam logic [3:0] S_IDLE   = 4'd0;
    localparam logic [3:0] S_DEC    = 4'd1;
    localparam logic [3:0] S_SCAN   = 4'd2;
    localparam logic [3:0] S_ADDF   = 4'd3;
    localparam logic [3:0] S_PICK   = 4'd4;
    localparam logic [3:0] S_BCHK   = 4'd5;
    localparam logic [3:0] S_QRD    = 4'd6;
    localparam logic [3:0] S_QEV    = 4'd7;
    localparam logic [3:0] S_GROW   = 4'd8;
    localparam logic [3:0] S_COMMIT = 4'd9;
    localparam logic [3:0] S_DONE   = 4'd10;

    logic [3:0] r_state;
    logic [3:0] n_state;

    assign o_busy = (r_state != S_IDLE);

    always_comb begin
        n_state = r_state;
        o_cmd   = '0;
        case (r_state)
            S_IDLE: begin
                if (i_start) begin
                    o_cmd.load = 1'b1;
                    n_state    = S_DEC;
                end
            end
            S_DEC: begin
                if (i_sts.arg_bad) begin
                    o_cmd.bad = 1'b1;
                    n_state   = S_DONE;
                end else begin
                    case (i_sts.op)
                        OP_BALANCE: n_state = S_SCAN;
                        OP_ADD:     n_state = S_SCAN;
                        OP_DELETE:  n_state = i_sts.has_q ? S_SCAN : S_COMMIT;
                        default: begin
                            if (i_sts.shrink) begin
                                n_state = S_QRD;
                            end else if (i_sts.grow) begin
                                n_state = S_SCAN;
                            end else begin
                                n_state = S_DONE;
                            end
                        end
                    endcase
                end
            end
            S_SCAN: begin
                o_cmd.slot_step = 1'b1;
                if (i_sts.slot_last) begin
                    n_state = (i_sts.op == OP_ADD) ? S_ADDF : S_PICK;
                end
            end
            S_ADDF: begin
                o_cmd.add_fin = 1'b1;
                n_state       = S_DONE;
            end
            S_PICK: begin
                o_cmd.pick_fin = 1'b1;
                case (i_sts.op)
                    OP_BALANCE: n_state = S_BCHK;
                    OP_DELETE:  n_state = S_QRD;
                    default:    n_state = S_GROW;
                endcase
            end
            S_BCHK: begin
                n_state = i_sts.can_move ? S_QRD : S_DONE;
            end
            S_QRD: begin
                if (i_sts.q_end) begin
                    n_state = S_COMMIT;
                end else begin
                    o_cmd.q_rd = 1'b1;
                    n_state    = S_QEV;
                end
            end
            S_QEV: begin
                o_cmd.q_ev = 1'b1;
                if (i_sts.op == OP_BALANCE && i_sts.hit) begin
                    n_state = S_DONE;
                end else begin
                    n_state = S_QRD;
                end
            end
            S_GROW: begin
                if (i_sts.q_end) begin
                    n_state = S_COMMIT;
                end else begin
                    o_cmd.grow_wr = 1'b1;
                end
            end
            S_COMMIT: begin
                o_cmd.commit = 1'b1;
                n_state      = S_DONE;
            end
            S_DONE: begin
                o_cmd.done = 1'b1;
                n_state    = S_IDLE;
            end
            default: begin
                n_state = S_IDLE;
            end
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state <= S_IDLE;
        end else begin
            r_state <= n_state;
        end
    end

endmodule

`default_nettype wire

/* rtl/core/rqb_datapath.sv */
// Datapath of the RSS queue balancer: slot records, indirection table and result.
// Depends on rqb_pkg and instantiates rqb_ram for the queue owner table.
`default_nettype none

module rqb_datapath #(
    parameter int WORKER_SLOTS = rqb_pkg::WORKER_SLOTS_DEF,
    parameter int QUEUE_COUNT  = rqb_pkg::QUEUE_COUNT_DEF
) (
    input  wire logic                          i_clk,
    input  wire logic                          i_rst_n,
    input  wire logic [rqb_pkg::OP_W-1:0]      i_operation,
    input  wire logic [rqb_pkg::PID_W-1:0]     i_worker_pid,
    input  wire logic [rqb_pkg::STAMP_W-1:0]   i_start_stamp,
    input  wire logic [rqb_pkg::TSLOT_W-1:0]   i_target_slot,
    input  wire logic [rqb_pkg::NSIZE_W-1:0]   i_new_table_size,
    input  wire logic                          i_cfg_we,
    input  wire logic [rqb_pkg::PID_W-1:0]     i_cfg_pid,
    input  rqb_pkg::t_cmd                      i_cmd,
    output rqb_pkg::t_sts                      o_sts,
    output logic [rqb_pkg::STATUS_W-1:0]       o_status,
    output logic [rqb_pkg::OSLOT_W-1:0]        o_slot_used,
    output logic [rqb_pkg::OSLOT_W-1:0]        o_from_slot,
    output logic [rqb_pkg::MQ_W-1:0]           o_moved_queue,
    output logic [rqb_pkg::MCNT_W-1:0]         o_moved_count,
    output logic                               o_all_workers_gone,
    output logic                               o_done
);
    import rqb_pkg::*;

    localparam int SW   = $clog2(WORKER_SLOTS);
    localparam int OW   = $clog2(WORKER_SLOTS + 1);
    localparam int QAW  = (QUEUE_COUNT > 1) ? $clog2(QUEUE_COUNT) : 1;
    localparam int QCW  = $clog2(QUEUE_COUNT + 1);
    localparam int CMPW = (QCW > NSIZE_W) ? QCW + 1 : NSIZE_W + 1;
    localparam logic [OW-1:0] OWNER_NONE = OW'(WORKER_SLOTS);

    // Slot records.
    logic             r_active [WORKER_SLOTS];
    logic [PID_W-1:0] r_pid    [WORKER_SLOTS];
    logic [31:0]      r_start  [WORKER_SLOTS];
    logic [QCW-1:0]   r_qcnt   [WORKER_SLOTS];
    logic [QCW-1:0]   r_size;
    logic [PID_W-1:0] r_ctl_pid;
    logic [QUEUE_COUNT-1:0] r_qvld;

    // Captured operation.
    logic [OP_W-1:0]    r_op;
    logic [PID_W-1:0]   r_wpid;
    logic [STAMP_W-1:0] r_stamp;
    logic [TSLOT_W-1:0] r_target;
    logic [NSIZE_W-1:0] r_nsize;

    // Slot scan.
    logic [SW-1:0]  r_si;
    logic           r_pok, r_kok, r_dup, r_fok;
    logic [SW-1:0]  r_pick, r_kick, r_free;
    logic [QCW-1:0] r_pcnt, r_kcnt;
    logic [31:0]    r_pstart, r_kstart;

    // Table walk.
    logic [QCW-1:0] r_qi, r_qend;
    logic           r_rvld;
    logic [OW-1:0]  ram_rdata;
    logic [OW-1:0]  owner;
    logic           ram_we;
    logic [OW-1:0]  ram_wdata;

    // Result.
    logic [STATUS_W-1:0] r_status;
    logic [SW-1:0]       r_used, r_from;
    logic [QCW-1:0]      r_mq, r_cnt;
    logic                r_gone, r_done;

    logic [CMPW-1:0] nsize_w, size_w;
    logic            tgt_range;
    logic [SW-1:0]   tgt;
    logic            others_active;
    logic            del_bad;
    logic            sel_ok, skip_i;
    logic [PID_W-1:0] pid_i;
    logic [SW-1:0]   pk_pick, pk_kick;
    logic [QCW-1:0]  pk_pcnt, pk_kcnt;
    logic [31:0]     pk_pstart;
    logic [SW-1:0]   own_idx;

    assign nsize_w   = CMPW'(i_new_table_size);
    assign size_w    = CMPW'(r_size);
    assign tgt_range = (32'(r_target) < WORKER_SLOTS);
    assign tgt       = SW'(r_target);
    assign owner     = r_rvld ? ram_rdata : OWNER_NONE;
    assign own_idx   = SW'(owner);
    assign pid_i     = (r_si == '0) ? r_ctl_pid : r_pid[r_si];
    assign skip_i    = (r_op == OP_DELETE) && (r_si == tgt);
    assign sel_ok    = (r_si != '0) && r_active[r_si] && !skip_i;
    assign del_bad   = (r_target == '0) || !tgt_range || !r_active[tgt];

    always_comb begin
        others_active = 1'b0;
        for (int s = 1; s < WORKER_SLOTS; s++) begin
            others_active = others_active | r_active[s];
        end
    end

    // Final choice of receiver and donor once the slot scan is over.
    always_comb begin
        pk_pick   = r_pok ? r_pick : '0;
        pk_pcnt   = r_pok ? r_pcnt : r_qcnt[0];
        pk_pstart = r_pstart;
        pk_kick   = r_kick;
        pk_kcnt   = r_kcnt;
        if (!r_kok || r_qcnt[0] != '0) begin
            pk_kick = '0;
            pk_kcnt = r_qcnt[0];
        end else if ({1'b0, r_kcnt} <= {1'b0, pk_pcnt} + (QCW + 1)'(1) &&
                     r_kstart >= pk_pstart) begin
            pk_kick = pk_pick;
            pk_kcnt = pk_pcnt;
        end
    end

    always_comb begin
        o_sts.op = r_op;
        case (r_op)
            OP_ADD:    o_sts.arg_bad = (r_wpid == '0);
            OP_DELETE: o_sts.arg_bad = del_bad;
            OP_RESIZE: o_sts.arg_bad = (CMPW'(r_nsize) > CMPW'(QUEUE_COUNT));
            default:   o_sts.arg_bad = 1'b0;
        endcase
        o_sts.shrink    = (CMPW'(r_nsize) < size_w);
        o_sts.grow      = (CMPW'(r_nsize) > size_w);
        o_sts.has_q     = (r_qcnt[tgt] != '0);
        o_sts.slot_last = (r_si == SW'(WORKER_SLOTS - 1));
        o_sts.q_end     = (r_qi >= r_qend);
        o_sts.can_move  = (r_pick != '0) && (r_pick != r_kick) && (r_kcnt != '0);
        o_sts.hit       = (owner == OW'(r_kick));
    end

    always_comb begin
        ram_we    = 1'b0;
        ram_wdata = OW'(r_pick);
        if (i_cmd.grow_wr) begin
            ram_we = 1'b1;
        end else if (i_cmd.q_ev) begin
            if (r_op == OP_BALANCE) begin
                ram_we = o_sts.hit;
            end else if (r_op == OP_DELETE) begin
                ram_we = (owner == OW'(r_target));
            end
        end
    end

    rqb_ram #(
        .WIDTH(OW),
        .DEPTH(QUEUE_COUNT)
    ) u_owner_ram (
        .i_clk  (i_clk),
        .i_we   (ram_we),
        .i_waddr(r_qi[QAW-1:0]),
        .i_wdata(ram_wdata),
        .i_re   (i_cmd.q_rd),
        .i_raddr(r_qi[QAW-1:0]),
        .o_rdata(ram_rdata)
    );

    // Operation registers, scan state and result.
    always_ff @(posedge i_clk) begin
        if (i_cmd.load) begin
            r_op     <= i_operation;
            r_wpid   <= i_worker_pid;
            r_stamp  <= i_start_stamp;
            r_target <= i_target_slot;
            r_nsize  <= i_new_table_size;
            r_si     <= '0;
            r_pok    <= 1'b0;
            r_kok    <= 1'b0;
            r_dup    <= 1'b0;
            r_fok    <= 1'b0;
            r_status <= ST_OK;
            r_used   <= '0;
            r_from   <= '0;
            r_mq     <= '0;
            r_cnt    <= '0;
            case (i_operation)
                OP_BALANCE: begin
                    r_qi   <= '0;
                    r_qend <= r_size;
                end
                OP_DELETE: begin
                    r_qi   <= '0;
                    r_qend <= QCW'(QUEUE_COUNT);
                end
                default: begin
                    if (nsize_w < size_w) begin
                        r_qi   <= QCW'(i_new_table_size);
                        r_qend <= r_size;
                    end else begin
                        r_qi   <= r_size;
                        r_qend <= QCW'(i_new_table_size);
                    end
                end
            endcase
        end
        if (i_cmd.bad) begin
            r_status <= ST_BAD_ARG;
        end
        if (i_cmd.slot_step) begin
            r_si <= r_si + SW'(1);
            if (r_op == OP_ADD) begin
                if (r_active[r_si] && pid_i == r_wpid) begin
                    r_dup <= 1'b1;
                end
                if (r_si != '0 && !r_active[r_si] && !r_fok) begin
                    r_fok  <= 1'b1;
                    r_free <= r_si;
                end
            end else if (sel_ok) begin
                if (!r_pok || r_pcnt > r_qcnt[r_si]) begin
                    r_pok    <= 1'b1;
                    r_pick   <= r_si;
                    r_pcnt   <= r_qcnt[r_si];
                    r_pstart <= r_start[r_si];
                end
                if (!r_kok || r_kcnt < r_qcnt[r_si]) begin
                    r_kok    <= 1'b1;
                    r_kick   <= r_si;
                    r_kcnt   <= r_qcnt[r_si];
                    r_kstart <= r_start[r_si];
                end
            end
        end
        if (i_cmd.add_fin) begin
            if (r_dup) begin
                r_status <= ST_DUP_PID;
            end else if (!r_fok) begin
                r_status <= ST_NO_SLOT;
            end else begin
                r_used <= r_free;
            end
        end
        if (i_cmd.pick_fin) begin
            r_pick <= pk_pick;
            r_pcnt <= pk_pcnt;
            r_kick <= pk_kick;
            r_kcnt <= pk_kcnt;
            r_used <= pk_pick;
        end
        if (i_cmd.q_rd) begin
            r_rvld <= r_qvld[r_qi[QAW-1:0]];
        end
        if (i_cmd.q_ev) begin
            r_qi <= r_qi + QCW'(1);
            if (r_op == OP_BALANCE) begin
                if (o_sts.hit) begin
                    r_from <= r_kick;
                    r_mq   <= r_qi;
                    r_cnt  <= QCW'(1);
                end
            end else if (r_op == OP_DELETE) begin
                if (owner == OW'(r_target)) begin
                    r_cnt <= r_cnt + QCW'(1);
                end
            end else begin
                r_cnt <= r_cnt + QCW'(1);
            end
        end
        if (i_cmd.grow_wr) begin
            r_qi  <= r_qi + QCW'(1);
            r_cnt <= r_cnt + QCW'(1);
        end
        if (i_cmd.done) begin
            r_gone <= !others_active;
        end
    end

    // Slot records, table size and valid bits of the owner table.
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            for (int s = 0; s < WORKER_SLOTS; s++) begin
                r_active[s] <= (s == 0);
                r_pid[s]    <= '0;
                r_start[s]  <= '0;
                r_qcnt[s]   <= '0;
            end
            r_size    <= '0;
            r_ctl_pid <= CTL_PID_RESET;
            r_qvld    <= '0;
            r_done    <= 1'b0;
        end else begin
            r_done <= i_cmd.done;
            if (i_cfg_we) begin
                r_ctl_pid <= i_cfg_pid;
            end
            if (i_cmd.add_fin && !r_dup && r_fok) begin
                r_active[r_free] <= 1'b1;
                r_pid[r_free]    <= r_wpid;
                r_start[r_free]  <= r_stamp;
                r_qcnt[r_free]   <= '0;
            end
            if (ram_we) begin
                r_qvld[r_qi[QAW-1:0]] <= 1'b1;
            end
            if (i_cmd.q_ev) begin
                if (r_op == OP_BALANCE) begin
                    if (o_sts.hit) begin
                        r_qcnt[r_kick] <= r_kcnt - QCW'(1);
                        r_qcnt[r_pick] <= r_pcnt + QCW'(1);
                    end
                end else if (r_op == OP_RESIZE) begin
                    r_qvld[r_qi[QAW-1:0]] <= 1'b0;
                    if (owner < OWNER_NONE && r_qcnt[own_idx] != '0) begin
                        r_qcnt[own_idx] <= r_qcnt[own_idx] - QCW'(1);
                    end
                end
            end
            if (i_cmd.commit) begin
                if (r_op == OP_DELETE) begin
                    if (r_cnt != '0) begin
                        r_qcnt[r_pick] <= r_pcnt + r_cnt;
                    end
                    r_active[tgt] <= 1'b0;
                    r_pid[tgt]    <= '0;
                    r_start[tgt]  <= '0;
                    r_qcnt[tgt]   <= '0;
                end else if (r_op == OP_RESIZE) begin
                    r_size <= QCW'(r_nsize);
                    if (CMPW'(r_nsize) > size_w) begin
                        r_qcnt[r_pick] <= r_pcnt + r_cnt;
                    end
                end
            end
        end
    end

    assign o_status           = r_status;
    assign o_slot_used        = OSLOT_W'(r_used);
    assign o_from_slot        = OSLOT_W'(r_from);
    assign o_moved_queue      = MQ_W'(r_mq);
    assign o_moved_count      = MCNT_W'(r_cnt);
    assign o_all_workers_gone = r_gone;
    assign o_done             = r_done;

endmodule

`default_nettype wire

/* rtl/core/rss_queue_balancer_unit.sv */
// Top level of the RSS queue balancer: controller, datapath and configuration port.
// Depends on rqb_pkg, rqb_ctrl and rqb_datapath.
`default_nettype none

// An operation is taken when start is high and busy is low; exactly one result
// beat follows, shown for a single cycle with o_done high, and the receiver
// cannot hold it off, so it must be captured in that cycle. busy stays high
// from the cycle after acceptance until the result is finished, and the
// result beat appears in the first cycle with busy low again. The length of
// an operation is set by a scan of the slot records, one slot per cycle, and a
// walk of the indirection table, which reads one entry at a time through its
// single read port. Add scans the slot records only. Balance scans them and
// then walks the table up to and including the first queue of the donor.
// Delete of a worker that owns queues scans them and walks the whole table.
// Growing the table scans them and then writes each added entry; shrinking
// walks only the removed entries, with no scan. Rejected operations do neither.
// The owner table needs no clearing pass after reset: valid bits in
// flip-flops mark entries that were never written. The controller process id
// may be written through the configuration channel, which is always ready,
// but only while no operation is in flight.
module rss_queue_balancer_unit #(
    parameter int WORKER_SLOTS = rqb_pkg::WORKER_SLOTS_DEF,
    parameter int QUEUE_COUNT  = rqb_pkg::QUEUE_COUNT_DEF
) (
    input  wire logic                          i_clk,
    input  wire logic                          i_rst_n,
    input  wire logic                          start,
    output logic                               busy,
    input  wire logic [rqb_pkg::OP_W-1:0]      i_operation,
    input  wire logic [rqb_pkg::PID_W-1:0]     i_worker_pid,
    input  wire logic [rqb_pkg::STAMP_W-1:0]   i_start_stamp,
    input  wire logic [rqb_pkg::TSLOT_W-1:0]   i_target_slot,
    input  wire logic [rqb_pkg::NSIZE_W-1:0]   i_new_table_size,
    input  wire logic                          i_cfg_valid,
    output logic                               o_cfg_ready,
    input  wire logic [rqb_pkg::PID_W-1:0]     i_cfg_controller_pid,
    output logic                               o_done,
    output logic [rqb_pkg::STATUS_W-1:0]       o_status,
    output logic [rqb_pkg::OSLOT_W-1:0]        o_slot_used,
    output logic [rqb_pkg::OSLOT_W-1:0]        o_from_slot,
    output logic [rqb_pkg::MQ_W-1:0]           o_moved_queue,
    output logic [rqb_pkg::MCNT_W-1:0]         o_moved_count,
    output logic                               o_all_workers_gone
);
    import rqb_pkg::*;

    t_cmd cmd;
    t_sts sts;
    logic busy_int;

    // Ready is tied high; the user must make writes to the register only while idle, as the block does not enforce it.
    assign o_cfg_ready = 1'b1;
    assign busy        = busy_int;

    rqb_ctrl u_ctrl (
        .i_clk  (i_clk),
        .i_rst_n(i_rst_n),
        .i_start(start),
        .i_sts  (sts),
        .o_cmd  (cmd),
        .o_busy (busy_int)
    );

    rqb_datapath #(
        .WORKER_SLOTS(WORKER_SLOTS),
        .QUEUE_COUNT (QUEUE_COUNT)
    ) u_dp (
        .i_clk             (i_clk),
        .i_rst_n           (i_rst_n),
        .i_operation       (i_operation),
        .i_worker_pid      (i_worker_pid),
        .i_start_stamp     (i_start_stamp),
        .i_target_slot     (i_target_slot),
        .i_new_table_size  (i_new_table_size),
        .i_cfg_we          (i_cfg_valid),
        .i_cfg_pid         (i_cfg_controller_pid),
        .i_cmd             (cmd),
        .o_sts             (sts),
        .o_status          (o_status),
        .o_slot_used       (o_slot_used),
        .o_from_slot       (o_from_slot),
        .o_moved_queue     (o_moved_queue),
        .o_moved_count     (o_moved_count),
        .o_all_workers_gone(o_all_workers_gone),
        .o_done            (o_done)
    );

endmodule

`default_nettype wire

/* bench/testbench.sv */
// Self-checking testbench for the RSS queue balancer top level.
// Depends on rqb_pkg and rss_queue_balancer_unit; a built-in predictor checks every result.
`timescale 1ns / 100ps

module testbench;
    import rqb_pkg::*;

    localparam int SLOTS     = WORKER_SLOTS_DEF;
    localparam int QUEUES    = QUEUE_COUNT_DEF;
    localparam int NO_OWNER  = SLOTS;
    localparam int IDLE_LIMIT = 2000;

    typedef struct {
        logic [OP_W-1:0]    op;
        logic [PID_W-1:0]   pid;
        logic [STAMP_W-1:0] stamp;
        logic [TSLOT_W-1:0] tslot;
        logic [NSIZE_W-1:0] nsize;
    } t_op_item;

    typedef struct {
        logic [STATUS_W-1:0] status;
        logic [OSLOT_W-1:0]  used;
        logic [OSLOT_W-1:0]  from;
        logic [MQ_W-1:0]     mq;
        logic [MCNT_W-1:0]   cnt;
        logic                gone;
    } t_op_result;

    logic i_clk = 1'b0;
    logic i_rst_n = 1'b0;
    logic start = 1'b0;
    logic busy;
    logic [OP_W-1:0]    i_operation = '0;
    logic [PID_W-1:0]   i_worker_pid = '0;
    logic [STAMP_W-1:0] i_start_stamp = '0;
    logic [TSLOT_W-1:0] i_target_slot = '0;
    logic [NSIZE_W-1:0] i_new_table_size = '0;
    logic i_cfg_valid = 1'b0;
    logic o_cfg_ready;
    logic [PID_W-1:0] i_cfg_controller_pid = '0;
    logic o_done;
    logic [STATUS_W-1:0] o_status;
    logic [OSLOT_W-1:0]  o_slot_used;
    logic [OSLOT_W-1:0]  o_from_slot;
    logic [MQ_W-1:0]     o_moved_queue;
    logic [MCNT_W-1:0]   o_moved_count;
    logic o_all_workers_gone;

    rss_queue_balancer_unit u_dut (
        .i_clk(i_clk), .i_rst_n(i_rst_n), .start(start), .busy(busy),
        .i_operation(i_operation), .i_worker_pid(i_worker_pid),
        .i_start_stamp(i_start_stamp), .i_target_slot(i_target_slot),
        .i_new_table_size(i_new_table_size),
        .i_cfg_valid(i_cfg_valid), .o_cfg_ready(o_cfg_ready),
        .i_cfg_controller_pid(i_cfg_controller_pid),
        .o_done(o_done), .o_status(o_status), .o_slot_used(o_slot_used),
        .o_from_slot(o_from_slot), .o_moved_queue(o_moved_queue),
        .o_moved_count(o_moved_count), .o_all_workers_gone(o_all_workers_gone)
    );

    always begin
        #5 i_clk = 1'b1;
        #5 i_clk = 1'b0;
    end

    // Mirror of the balancer state, updated as each operation is accepted.
    logic [4:0]         own_tbl [QUEUES];
    logic [6:0]         tbl_size;
    logic               slot_on [SLOTS];
    logic [PID_W-1:0]   slot_id [SLOTS];
    logic [STAMP_W-1:0] slot_t0 [SLOTS];
    logic [6:0]         slot_load [SLOTS];
    logic [PID_W-1:0]   ctl_pid;

    t_op_item   pending_ops[$];
    t_op_result expected_results[$];
    int idle_pct = 0;
    int mismatches = 0;
    int quiet_cycles = 0;

    // Least-loaded (pick) and most-loaded (kick) worker, skipping one slot. Kick
    // falls back to slot zero when no other worker is active or the controller still
    // owns queues; it collapses onto pick when at most one queue above it and no older.
    function automatic void find_pick_kick(input int skip, output int pk, output int kk);
        pk = NO_OWNER;
        kk = NO_OWNER;
        for (int s = 1; s < SLOTS; s++) begin
            if (slot_on[s] && s != skip) begin
                if (pk == NO_OWNER || slot_load[pk] > slot_load[s]) pk = s;
                if (kk == NO_OWNER || slot_load[kk] < slot_load[s]) kk = s;
            end
        end
        if (pk == NO_OWNER) pk = 0;
        if (kk == NO_OWNER || slot_load[0] != 0) begin
            kk = 0;
        end else if (int'(slot_load[kk]) <= int'(slot_load[pk]) + 1 &&
                     slot_t0[kk] >= slot_t0[pk]) begin
            kk = pk;
        end
    endfunction

    function automatic t_op_result apply_operation(input t_op_item it);
        t_op_result r;
        int pk, kk, s;
        logic found;
        r = '{ST_OK, '0, '0, '0, '0, 1'b0};
        case (it.op)
            OP_BALANCE: begin
                find_pick_kick(NO_OWNER, pk, kk);
                r.used = OSLOT_W'(pk);
                if (pk != 0 && pk != kk && slot_load[kk] != 0) begin
                    for (int q = 0; q < tbl_size; q++) begin
                        if (own_tbl[q] == kk) begin
                            own_tbl[q] = 5'(pk);
                            slot_load[kk]--;
                            slot_load[pk]++;
                            r.from = OSLOT_W'(kk);
                            r.mq = MQ_W'(q);
                            r.cnt = MCNT_W'(1);
                            break;
                        end
                    end
                end
            end
            OP_ADD: begin
                if (it.pid == '0) begin
                    r.status = ST_BAD_ARG;
                end else begin
                    found = 1'b0;
                    for (int q = 0; q < SLOTS; q++)
                        if (slot_on[q] && ((q == 0) ? ctl_pid : slot_id[q]) == it.pid)
                            found = 1'b1;
                    if (found) begin
                        r.status = ST_DUP_PID;
                    end else begin
                        s = 1;
                        while (s < SLOTS && slot_on[s]) s++;
                        if (s >= SLOTS) begin
                            r.status = ST_NO_SLOT;
                        end else begin
                            slot_on[s] = 1'b1;
                            slot_id[s] = it.pid;
                            slot_t0[s] = it.stamp;
                            slot_load[s] = '0;
                            r.used = OSLOT_W'(s);
                        end
                    end
                end
            end
            OP_DELETE: begin
                s = int'(it.tslot);
                if (s == 0 || !slot_on[s]) begin
                    r.status = ST_BAD_ARG;
                end else begin
                    if (slot_load[s] != 0) begin
                        find_pick_kick(s, pk, kk);
                        r.used = OSLOT_W'(pk);
                        for (int q = 0; q < QUEUES; q++) begin
                            if (own_tbl[q] == s) begin
                                own_tbl[q] = 5'(pk);
                                slot_load[pk]++;
                                r.cnt++;
                            end
                        end
                    end
                    slot_on[s] = 1'b0;
                    slot_id[s] = '0;
                    slot_t0[s] = '0;
                    slot_load[s] = '0;
                end
            end
            default: begin
                if (it.nsize > QUEUES) begin
                    r.status = ST_BAD_ARG;
                end else if (it.nsize < tbl_size) begin
                    for (int q = it.nsize; q < tbl_size; q++) begin
                        if (own_tbl[q] < NO_OWNER && slot_load[own_tbl[q]] != 0)
                            slot_load[own_tbl[q]]--;
                        own_tbl[q] = 5'(NO_OWNER);
                        r.cnt++;
                    end
                    tbl_size = it.nsize;
                end else if (it.nsize > tbl_size) begin
                    find_pick_kick(NO_OWNER, pk, kk);
                    r.used = OSLOT_W'(pk);
                    for (int q = tbl_size; q < it.nsize; q++) begin
                        own_tbl[q] = 5'(pk);
                        slot_load[pk]++;
                        r.cnt++;
                    end
                    tbl_size = it.nsize;
                end
            end
        endcase
        r.gone = 1'b1;
        for (int q = 1; q < SLOTS; q++)
            if (slot_on[q]) r.gone = 1'b0;
        return r;
    endfunction

    // Driver: presents the next pending operation and holds it until the beat
    // is taken. The prediction is made at the moment of acceptance, so the
    // mirror always sees operations in the order the block executes them.
    always @(posedge i_clk) begin
        t_op_item nx;
        if (i_rst_n) begin
            if (start && !busy) begin
                expected_results.push_back(apply_operation(pending_ops.pop_front()));
            end
            if ((!start || !busy) && pending_ops.size() > 0 &&
                $urandom_range(99) >= idle_pct) begin
                nx = pending_ops[0];
                start <= 1'b1;
                i_operation <= nx.op;
                i_worker_pid <= nx.pid;
                i_start_stamp <= nx.stamp;
                i_target_slot <= nx.tslot;
                i_new_table_size <= nx.nsize;
            end else if (!start || !busy) begin
                start <= 1'b0;
            end
        end
    end

    // Monitor: the result is shown for one cycle only, so every o_done beat
    // is compared against the oldest outstanding prediction at once. It also
    // keeps the count of cycles in which no beat was taken on any channel.
    always @(posedge i_clk) begin
        t_op_result e;
        if (i_rst_n) begin
            if (o_done || (start && !busy) || (i_cfg_valid && o_cfg_ready)) begin
                quiet_cycles <= 0;
            end else begin
                quiet_cycles <= quiet_cycles + 1;
            end
            if (o_done) begin
                if (expected_results.size() == 0) begin
                    mismatches++;
                    if (mismatches <= 10)
                        $display("unexpected result beat at %0t", $realtime);
                end else begin
                    e = expected_results.pop_front();
                    if (o_status !== e.status || o_slot_used !== e.used ||
                        o_from_slot !== e.from || o_moved_queue !== e.mq ||
                        o_moved_count !== e.cnt || o_all_workers_gone !== e.gone) begin
                        mismatches++;
                        if (mismatches <= 10)
                            $display({"mismatch at %0t: exp st=%0d slot=%0d from=%0d q=%0d",
                                      " n=%0d gone=%0d, got st=%0d slot=%0d from=%0d q=%0d",
                                      " n=%0d gone=%0d"},
                                     $realtime, e.status, e.used, e.from, e.mq, e.cnt, e.gone,
                                     o_status, o_slot_used, o_from_slot, o_moved_queue,
                                     o_moved_count, o_all_workers_gone);
                    end
                end
            end
        end
    end

    // Watchdog: too long without an accepted beat means the block has hung.
    always @(posedge i_clk) begin
        if (quiet_cycles >= IDLE_LIMIT) begin
            $display("Verification failed");
            $finish;
        end
    end

    function automatic t_op_item mk(input logic [OP_W-1:0] op, input logic [PID_W-1:0] pid,
                                    input logic [STAMP_W-1:0] st, input logic [TSLOT_W-1:0] ts,
                                    input logic [NSIZE_W-1:0] ns);
        t_op_item it;
        it.op = op; it.pid = pid; it.stamp = st; it.tslot = ts; it.nsize = ns;
        return it;
    endfunction

    // Mostly well-formed traffic: ids from a small pool so duplicates happen,
    // table sizes within range, and deletes spread over every slot; the rest
    // is full-width noise.
    function automatic t_op_item random_item();
        t_op_item it;
        int w;
        it = mk(OP_W'($urandom_range(3)), PID_W'($urandom_range(1, 40)), $urandom,
                TSLOT_W'($urandom_range(15)), NSIZE_W'($urandom_range(QUEUES)));
        w = $urandom_range(99);
        if (w < 35) it.op = OP_BALANCE;
        else if (w < 60) it.op = OP_ADD;
        if ($urandom_range(9) == 0) it.pid = PID_W'($urandom);
        if ($urandom_range(29) == 0) it.pid = '0;
        if ($urandom_range(9) == 0) it.nsize = NSIZE_W'($urandom);
        if ($urandom_range(3) == 0) it.stamp = STAMP_W'($urandom_range(3));
        return it;
    endfunction

    task automatic write_ctl_pid(input logic [PID_W-1:0] v);
        @(posedge i_clk);
        i_cfg_valid <= 1'b1;
        i_cfg_controller_pid <= v;
        forever begin
            @(negedge i_clk);
            if (o_cfg_ready) break;
        end
        @(posedge i_clk);
        i_cfg_valid <= 1'b0;
        ctl_pid = v;
    endtask

    task automatic drain();
        while (pending_ops.size() > 0 || expected_results.size() > 0 || start)
            @(posedge i_clk);
        repeat (5) @(posedge i_clk);
        while (busy) @(posedge i_clk);
    endtask

    initial begin
        int pcts[4] = '{0, 48, 0, 15};
        logic [PID_W-1:0] pids[4] = '{22'h3FFFFF, 22'd5, 22'd1, 22'd27};
        for (int q = 0; q < QUEUES; q++) own_tbl[q] = 5'(NO_OWNER);
        for (int s = 0; s < SLOTS; s++) begin
            slot_on[s] = (s == 0);
            slot_id[s] = '0;
            slot_t0[s] = '0;
            slot_load[s] = '0;
        end
        tbl_size = '0;
        ctl_pid = CTL_PID_RESET;
        repeat (7) @(posedge i_clk);
        i_rst_n <= 1'b1;

        // Directed part, run with the controller id left at its reset value.
        pending_ops.push_back(mk(OP_BALANCE, '0, '0, '0, '0));
        pending_ops.push_back(mk(OP_ADD, '0, '0, '0, '0));
        pending_ops.push_back(mk(OP_ADD, CTL_PID_RESET, '0, '0, '0));
        pending_ops.push_back(mk(OP_RESIZE, '0, '0, '0, NSIZE_W'(QUEUES)));
        pending_ops.push_back(mk(OP_ADD, 22'h3FFFFF, 32'hFFFFFFFF, '0, '0));
        pending_ops.push_back(mk(OP_ADD, 22'd2, 32'h0, '0, '0));
        for (int k = 0; k < 8; k++) pending_ops.push_back(mk(OP_BALANCE, '0, '0, '0, '0));
        for (int k = 3; k < 17; k++)
            pending_ops.push_back(mk(OP_ADD, PID_W'(k), STAMP_W'(k), '0, '0));
        pending_ops.push_back(mk(OP_DELETE, '0, '0, '0, '0));
        pending_ops.push_back(mk(OP_DELETE, '0, '0, 4'd1, '0));
        pending_ops.push_back(mk(OP_DELETE, '0, '0, 4'd1, '0));
        pending_ops.push_back(mk(OP_DELETE, '0, '0, 4'd15, '0));
        pending_ops.push_back(mk(OP_RESIZE, '0, '0, '0, 7'd65));
        pending_ops.push_back(mk(OP_RESIZE, '0, '0, '0, 7'd127));
        pending_ops.push_back(mk(OP_RESIZE, '0, '0, '0, '0));
        pending_ops.push_back(mk(OP_RESIZE, '0, '0, '0, '0));
        pending_ops.push_back(mk(OP_RESIZE, '0, '0, '0, 7'd9));
        drain();

        // Random phases, each under its own controller id; the idling pattern is set per phase.
        for (int ph = 0; ph < 4; ph++) begin
            write_ctl_pid(pids[ph]);
            idle_pct = pcts[ph];
            for (int k = 0; k < 170; k++) pending_ops.push_back(random_item());
            drain();
        end

        repeat (20) @(posedge i_clk);
        if (mismatches == 0) begin
            $display("Verification passed");
        end else begin
            $display("Verification failed");
        end
        $finish;
    end

endmodule
